// ===== src/nrefl_pkg.sv =====
// ----------------------------------------------------------------------------
// nrefl_pkg
// Shared widths, the pipeline tag and helpers for the normalized 2D
// reflection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nrefl_pkg;

    // Field widths at the ports
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;

    // Front end: products, dot product, scaled terms, reflected vector
    localparam int PROD_W  = 32;
    localparam int DOT_W   = 33;
    localparam int TERM_W  = 49;
    localparam int R_W     = 49;
    localparam int MAG_W   = 48;
    localparam int V_SHIFT = 28;

    // Normalizer: leading-one index, normalized magnitudes, squares, sum
    localparam int MSB_W   = 6;
    localparam int NORM_W  = 31;
    localparam int SQ_W    = 62;
    localparam int SUM_W   = 63;

    // Square root: remainder and root
    localparam int REM_W   = 64;
    localparam int ROOT_W  = 32;

    // Divider: numerator, divisor, quotient
    localparam int DIVN_W  = 47;
    localparam int DIV_W   = 33;
    localparam int Q_W     = 15;
    localparam int Q_SHIFT = 15;

    localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);

    // Control that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic zero;
        logic neg_x;
        logic neg_y;
    } t_tag;

    // Index of the highest set bit; zero for an all-zero word
    function automatic logic [MSB_W-1:0] f_msb(input logic [MAG_W-1:0] x);
        logic [MSB_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (x[i]) begin
                idx = MSB_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== src/nrefl_front.sv =====
// ----------------------------------------------------------------------------
// nrefl_front
// Dot product, reflection r = v - 2(v.n)n and component magnitudes, in five
// register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrefl_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic signed [nrefl_pkg::IN_W-1:0]     i_incident_x,
    input  wire logic signed [nrefl_pkg::IN_W-1:0]     i_incident_y,
    input  wire logic signed [nrefl_pkg::IN_W-1:0]     i_normal_x,
    input  wire logic signed [nrefl_pkg::IN_W-1:0]     i_normal_y,
    output nrefl_pkg::t_tag                            o_tag,
    output logic [nrefl_pkg::MAG_W-1:0]                o_a,
    output logic [nrefl_pkg::MAG_W-1:0]                o_b
);

    // Stage 1: products
    logic                                  r1_valid;
    logic signed [nrefl_pkg::PROD_W-1:0]   r1_pxx, r1_pyy;
    logic signed [nrefl_pkg::IN_W-1:0]     r1_vx, r1_vy, r1_nx, r1_ny;

    // Stage 2: dot product
    logic                                  r2_valid;
    logic signed [nrefl_pkg::DOT_W-1:0]    r2_dot;
    logic signed [nrefl_pkg::IN_W-1:0]     r2_vx, r2_vy, r2_nx, r2_ny;

    // Stage 3: d times normal
    logic                                  r3_valid;
    logic signed [nrefl_pkg::TERM_W-1:0]   r3_tx, r3_ty;
    logic signed [nrefl_pkg::IN_W-1:0]     r3_vx, r3_vy;

    // Stage 4: reflected vector with 36 fraction bits
    logic                                  r4_valid;
    logic signed [nrefl_pkg::R_W-1:0]      r4_rx, r4_ry;

    // Stage 5: magnitudes and flags
    nrefl_pkg::t_tag                       r5_tag;
    logic [nrefl_pkg::MAG_W-1:0]           r5_a, r5_b;

    // Advance valid bits and the flags of the last stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid     <= 1'b0;
            r2_valid     <= 1'b0;
            r3_valid     <= 1'b0;
            r4_valid     <= 1'b0;
            r5_tag.valid <= 1'b0;
        end else if (i_en) begin
            r1_valid     <= i_valid;
            r2_valid     <= r1_valid;
            r3_valid     <= r2_valid;
            r4_valid     <= r3_valid;
            r5_tag.valid <= r4_valid;
            r5_tag.zero  <= (r4_rx == '0) && (r4_ry == '0);
            r5_tag.neg_x <= r4_rx[nrefl_pkg::R_W-1];
            r5_tag.neg_y <= r4_ry[nrefl_pkg::R_W-1];
        end
    end

    // Advance datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pxx <= i_incident_x * i_normal_x;
            r1_pyy <= i_incident_y * i_normal_y;
            r1_vx  <= i_incident_x;
            r1_vy  <= i_incident_y;
            r1_nx  <= i_normal_x;
            r1_ny  <= i_normal_y;

            r2_dot <= nrefl_pkg::DOT_W'(r1_pxx) + nrefl_pkg::DOT_W'(r1_pyy);
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;
            r2_nx  <= r1_nx;
            r2_ny  <= r1_ny;

            r3_tx  <= r2_dot * r2_nx;
            r3_ty  <= r2_dot * r2_ny;
            r3_vx  <= r2_vx;
            r3_vy  <= r2_vy;

            r4_rx  <= (nrefl_pkg::R_W'(r3_vx) <<< nrefl_pkg::V_SHIFT)
                      - (nrefl_pkg::R_W'(r3_tx) <<< 1);
            r4_ry  <= (nrefl_pkg::R_W'(r3_vy) <<< nrefl_pkg::V_SHIFT)
                      - (nrefl_pkg::R_W'(r3_ty) <<< 1);

            r5_a   <= r4_rx[nrefl_pkg::R_W-1] ? nrefl_pkg::MAG_W'(-r4_rx)
                                              : nrefl_pkg::MAG_W'(r4_rx);
            r5_b   <= r4_ry[nrefl_pkg::R_W-1] ? nrefl_pkg::MAG_W'(-r4_ry)
                                              : nrefl_pkg::MAG_W'(r4_ry);
        end
    end

    assign o_tag = r5_tag;
    assign o_a   = r5_a;
    assign o_b   = r5_b;

endmodule

`default_nettype wire

// ===== src/nrefl_norm.sv =====
// ----------------------------------------------------------------------------
// nrefl_norm
// Shifts both magnitudes so the larger one lands in [2^30, 2^31), then forms
// the sum of squares, in four register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrefl_norm (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire nrefl_pkg::t_tag                       i_tag,
    input  wire logic [nrefl_pkg::MAG_W-1:0]           i_a,
    input  wire logic [nrefl_pkg::MAG_W-1:0]           i_b,
    output nrefl_pkg::t_tag                            o_tag,
    output logic [nrefl_pkg::SUM_W-1:0]                o_sum,
    output logic [nrefl_pkg::NORM_W-1:0]               o_a,
    output logic [nrefl_pkg::NORM_W-1:0]               o_b
);

    localparam int EXT_W = nrefl_pkg::MAG_W + nrefl_pkg::NORM_W - 1;

    nrefl_pkg::t_tag                   r1_tag, r2_tag, r3_tag, r4_tag;
    logic [nrefl_pkg::MSB_W-1:0]       r1_msb;
    logic [nrefl_pkg::MAG_W-1:0]       r1_a, r1_b;
    logic [nrefl_pkg::NORM_W-1:0]      r2_a, r2_b, r3_a, r3_b, r4_a, r4_b;
    logic [nrefl_pkg::SQ_W-1:0]        r3_sqa, r3_sqb;
    logic [nrefl_pkg::SUM_W-1:0]       r4_sum;

    logic [EXT_W-1:0]                  w_ext_a, w_ext_b;

    // Place the leading one of the wider magnitude at bit 30; low bits drop
    always_comb begin
        w_ext_a = {r1_a, {(nrefl_pkg::NORM_W-1){1'b0}}} >> r1_msb;
        w_ext_b = {r1_b, {(nrefl_pkg::NORM_W-1){1'b0}}} >> r1_msb;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag.valid <= 1'b0;
            r2_tag.valid <= 1'b0;
            r3_tag.valid <= 1'b0;
            r4_tag.valid <= 1'b0;
        end else if (i_en) begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
            r4_tag <= r3_tag;
        end
    end

    // Advance datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_msb <= nrefl_pkg::f_msb(i_a | i_b);
            r1_a   <= i_a;
            r1_b   <= i_b;

            r2_a   <= w_ext_a[nrefl_pkg::NORM_W-1:0];
            r2_b   <= w_ext_b[nrefl_pkg::NORM_W-1:0];

            r3_sqa <= r2_a * r2_a;
            r3_sqb <= r2_b * r2_b;
            r3_a   <= r2_a;
            r3_b   <= r2_b;

            r4_sum <= nrefl_pkg::SUM_W'(r3_sqa) + nrefl_pkg::SUM_W'(r3_sqb);
            r4_a   <= r3_a;
            r4_b   <= r3_b;
        end
    end

    assign o_tag = r4_tag;
    assign o_sum = r4_sum;
    assign o_a   = r4_a;
    assign o_b   = r4_b;

endmodule

`default_nettype wire

// ===== src/nrefl_sqrt.sv =====
// ----------------------------------------------------------------------------
// nrefl_sqrt
// Pipelined integer square root: one root bit per register stage, restoring
// digit-by-digit method, floor result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrefl_sqrt (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire nrefl_pkg::t_tag                       i_tag,
    input  wire logic [nrefl_pkg::SUM_W-1:0]           i_sum,
    input  wire logic [nrefl_pkg::NORM_W-1:0]          i_a,
    input  wire logic [nrefl_pkg::NORM_W-1:0]          i_b,
    output nrefl_pkg::t_tag                            o_tag,
    output logic [nrefl_pkg::ROOT_W-1:0]               o_root,
    output logic [nrefl_pkg::NORM_W-1:0]               o_a,
    output logic [nrefl_pkg::NORM_W-1:0]               o_b
);

    nrefl_pkg::t_tag                   s_tag  [nrefl_pkg::ROOT_W+1];
    logic [nrefl_pkg::REM_W-1:0]       s_rem  [nrefl_pkg::ROOT_W+1];
    logic [nrefl_pkg::ROOT_W-1:0]      s_root [nrefl_pkg::ROOT_W+1];
    logic [nrefl_pkg::NORM_W-1:0]      s_a    [nrefl_pkg::ROOT_W+1];
    logic [nrefl_pkg::NORM_W-1:0]      s_b    [nrefl_pkg::ROOT_W+1];

    assign s_tag[0]  = i_tag;
    assign s_rem[0]  = nrefl_pkg::REM_W'(i_sum);
    assign s_root[0] = '0;
    assign s_a[0]    = i_a;
    assign s_b[0]    = i_b;

    genvar k;
    generate
        for (k = 0; k < nrefl_pkg::ROOT_W; k++) begin : g_stage
            localparam int BIT = nrefl_pkg::ROOT_W - 1 - k;

            nrefl_pkg::t_tag                   r_tag;
            logic [nrefl_pkg::REM_W-1:0]       r_rem, n_rem, w_trial;
            logic [nrefl_pkg::ROOT_W-1:0]      r_root, n_root;
            logic [nrefl_pkg::NORM_W-1:0]      r_a, r_b;

            // Try this root bit; keep it if the remainder covers it
            always_comb begin
                w_trial = (nrefl_pkg::REM_W'(s_root[k]) << (BIT + 1))
                          | (nrefl_pkg::REM_W'(1) << (2 * BIT));
                if (s_rem[k] >= w_trial) begin
                    n_rem  = s_rem[k] - w_trial;
                    n_root = s_root[k] | (nrefl_pkg::ROOT_W'(1) << BIT);
                end else begin
                    n_rem  = s_rem[k];
                    n_root = s_root[k];
                end
            end

            // Advance valid bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tag.valid <= 1'b0;
                end else if (i_en) begin
                    r_tag <= s_tag[k];
                end
            end

            // Advance datapath
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_a    <= s_a[k];
                    r_b    <= s_b[k];
                end
            end

            assign s_tag[k+1]  = r_tag;
            assign s_rem[k+1]  = r_rem;
            assign s_root[k+1] = r_root;
            assign s_a[k+1]    = r_a;
            assign s_b[k+1]    = r_b;
        end
    endgenerate

    assign o_tag  = s_tag[nrefl_pkg::ROOT_W];
    assign o_root = s_root[nrefl_pkg::ROOT_W];
    assign o_a    = s_a[nrefl_pkg::ROOT_W];
    assign o_b    = s_b[nrefl_pkg::ROOT_W];

endmodule

`default_nettype wire

// ===== src/nrefl_div.sv =====
// ----------------------------------------------------------------------------
// nrefl_div
// Two-lane pipelined restoring divider: q = floor((a*2^15 + L) / (2L)),
// one setup stage and one quotient bit per stage after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrefl_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire nrefl_pkg::t_tag                       i_tag,
    input  wire logic [nrefl_pkg::ROOT_W-1:0]          i_root,
    input  wire logic [nrefl_pkg::NORM_W-1:0]          i_a,
    input  wire logic [nrefl_pkg::NORM_W-1:0]          i_b,
    output nrefl_pkg::t_tag                            o_tag,
    output logic [nrefl_pkg::Q_W-1:0]                  o_q_x,
    output logic [nrefl_pkg::Q_W-1:0]                  o_q_y
);

    nrefl_pkg::t_tag                   s_tag [nrefl_pkg::Q_W+1];
    logic [nrefl_pkg::DIVN_W-1:0]      s_rem [nrefl_pkg::Q_W+1][2];
    logic [nrefl_pkg::Q_W-1:0]         s_q   [nrefl_pkg::Q_W+1][2];
    logic [nrefl_pkg::DIV_W-1:0]       s_div [nrefl_pkg::Q_W+1];

    // Setup stage: rounding numerator per lane, shared divisor 2L
    nrefl_pkg::t_tag                   r0_tag;
    logic [nrefl_pkg::DIVN_W-1:0]      r0_num [2];
    logic [nrefl_pkg::DIV_W-1:0]       r0_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_tag.valid <= 1'b0;
        end else if (i_en) begin
            r0_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_num[0] <= (nrefl_pkg::DIVN_W'(i_a) << nrefl_pkg::Q_SHIFT)
                         + nrefl_pkg::DIVN_W'(i_root);
            r0_num[1] <= (nrefl_pkg::DIVN_W'(i_b) << nrefl_pkg::Q_SHIFT)
                         + nrefl_pkg::DIVN_W'(i_root);
            r0_div    <= {i_root, 1'b0};
        end
    end

    assign s_tag[0]    = r0_tag;
    assign s_div[0]    = r0_div;
    assign s_rem[0][0] = r0_num[0];
    assign s_rem[0][1] = r0_num[1];
    assign s_q[0][0]   = '0;
    assign s_q[0][1]   = '0;

    genvar k, l;
    generate
        for (k = 0; k < nrefl_pkg::Q_W; k++) begin : g_stage
            localparam int BIT = nrefl_pkg::Q_W - 1 - k;

            nrefl_pkg::t_tag                   r_tag;
            logic [nrefl_pkg::DIV_W-1:0]       r_div;
            logic [nrefl_pkg::DIVN_W-1:0]      w_trial;

            assign w_trial = nrefl_pkg::DIVN_W'(s_div[k]) << BIT;

            // Advance valid bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tag.valid <= 1'b0;
                end else if (i_en) begin
                    r_tag <= s_tag[k];
                end
            end

            // Hold divisor alongside the item
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_div <= s_div[k];
                end
            end

            assign s_tag[k+1] = r_tag;
            assign s_div[k+1] = r_div;

            for (l = 0; l < 2; l++) begin : g_lane
                logic [nrefl_pkg::DIVN_W-1:0]  r_rem, n_rem;
                logic [nrefl_pkg::Q_W-1:0]     r_q, n_q;

                // Subtract the shifted divisor when it fits; set quotient bit
                always_comb begin
                    if (s_rem[k][l] >= w_trial) begin
                        n_rem = s_rem[k][l] - w_trial;
                        n_q   = s_q[k][l] | (nrefl_pkg::Q_W'(1) << BIT);
                    end else begin
                        n_rem = s_rem[k][l];
                        n_q   = s_q[k][l];
                    end
                end

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem <= n_rem;
                        r_q   <= n_q;
                    end
                end

                assign s_rem[k+1][l] = r_rem;
                assign s_q[k+1][l]   = r_q;
            end
        end
    endgenerate

    assign o_tag = s_tag[nrefl_pkg::Q_W];
    assign o_q_x = s_q[nrefl_pkg::Q_W][0];
    assign o_q_y = s_q[nrefl_pkg::Q_W][1];

endmodule

`default_nettype wire

// ===== src/normalized_reflection_2d_top.sv =====
// ----------------------------------------------------------------------------
// normalized_reflection_2d_top
// Reflects a Q8.8 vector about a Q2.14 normal and scales the result to unit
// length in Q2.14, rounded to nearest and saturated to +/-1.0.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   i_incident_x/y, i_normal_x/y
//   output   out        o_valid / i_stall   o_reflect_x/y, o_zero_length
//
// One transaction enters per clock while o_stall is low. Each result passes
// the front end, normalizer, square root, divider and output register.
// Most of the depth comes from the square root (one root bit per stage, 32
// stages) and the divider (one quotient bit per stage, 15 stages plus setup).
// Reset is synchronous, active low, and clears every valid bit.
// A stalled result moves into a skid register; the pipeline freezes only
// when the skid register is full, so o_stall is a register output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module normalized_reflection_2d_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [nrefl_pkg::IN_W-1:0]     i_incident_x,
    input  wire logic signed [nrefl_pkg::IN_W-1:0]     i_incident_y,
    input  wire logic signed [nrefl_pkg::IN_W-1:0]     i_normal_x,
    input  wire logic signed [nrefl_pkg::IN_W-1:0]     i_normal_y,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [nrefl_pkg::OUT_W-1:0]         o_reflect_x,
    output logic signed [nrefl_pkg::OUT_W-1:0]         o_reflect_y,
    output logic                                       o_zero_length
);

    logic                              w_en, w_take, w_new;

    nrefl_pkg::t_tag                   front_tag, norm_tag, sqrt_tag, div_tag;
    logic [nrefl_pkg::MAG_W-1:0]       front_a, front_b;
    logic [nrefl_pkg::SUM_W-1:0]       norm_sum;
    logic [nrefl_pkg::NORM_W-1:0]      norm_a, norm_b, sqrt_a, sqrt_b;
    logic [nrefl_pkg::ROOT_W-1:0]      sqrt_root;
    logic [nrefl_pkg::Q_W-1:0]         div_q_x, div_q_y;

    logic [nrefl_pkg::Q_W-1:0]         w_sat_x, w_sat_y;
    logic [nrefl_pkg::OUT_W-1:0]       w_mag_x, w_mag_y, w_res_x, w_res_y;

    logic                              r_out_valid, r_skid_valid;
    logic [nrefl_pkg::OUT_W-1:0]       r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic                              r_out_zero, r_skid_zero;

    // Freeze the pipeline only while the skid register holds a result
    assign w_en    = !r_skid_valid;
    assign w_take  = r_out_valid && !i_stall;
    assign w_new   = w_en && div_tag.valid;
    assign o_stall = r_skid_valid;

    nrefl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_valid),
        .i_incident_x (i_incident_x),
        .i_incident_y (i_incident_y),
        .i_normal_x   (i_normal_x),
        .i_normal_y   (i_normal_y),
        .o_tag        (front_tag),
        .o_a          (front_a),
        .o_b          (front_b)
    );

    nrefl_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (front_tag),
        .i_a     (front_a),
        .i_b     (front_b),
        .o_tag   (norm_tag),
        .o_sum   (norm_sum),
        .o_a     (norm_a),
        .o_b     (norm_b)
    );

    nrefl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (norm_tag),
        .i_sum   (norm_sum),
        .i_a     (norm_a),
        .i_b     (norm_b),
        .o_tag   (sqrt_tag),
        .o_root  (sqrt_root),
        .o_a     (sqrt_a),
        .o_b     (sqrt_b)
    );

    nrefl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (sqrt_tag),
        .i_root  (sqrt_root),
        .i_a     (sqrt_a),
        .i_b     (sqrt_b),
        .o_tag   (div_tag),
        .o_q_x   (div_q_x),
        .o_q_y   (div_q_y)
    );

    // Saturate to one, apply the sign, force zero on a zero-length vector
    always_comb begin
        w_sat_x = (div_q_x > nrefl_pkg::ONE_Q14) ? nrefl_pkg::ONE_Q14 : div_q_x;
        w_sat_y = (div_q_y > nrefl_pkg::ONE_Q14) ? nrefl_pkg::ONE_Q14 : div_q_y;
        w_mag_x = nrefl_pkg::OUT_W'(w_sat_x);
        w_mag_y = nrefl_pkg::OUT_W'(w_sat_y);
        if (div_tag.zero) begin
            w_res_x = '0;
            w_res_y = '0;
        end else begin
            w_res_x = div_tag.neg_x ? -w_mag_x : w_mag_x;
            w_res_y = div_tag.neg_y ? -w_mag_y : w_mag_y;
        end
    end

    // Output register and skid register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_new;
            end
        end else if (w_new) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Load output or skid payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_x    <= r_skid_x;
                r_out_y    <= r_skid_y;
                r_out_zero <= r_skid_zero;
            end else begin
                r_out_x    <= w_res_x;
                r_out_y    <= w_res_y;
                r_out_zero <= div_tag.zero;
            end
        end else if (w_new) begin
            r_skid_x    <= w_res_x;
            r_skid_y    <= w_res_y;
            r_skid_zero <= div_tag.zero;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_reflect_x   = r_out_x;
    assign o_reflect_y   = r_out_y;
    assign o_zero_length = r_out_zero;

endmodule

`default_nettype wire
